@@ rtl/spcm_pkg.sv @@
// ----------------------------------------------------------------------------
// Smoothed point to cursor map: shared package
// Field widths, display and camera constants, register indexes and the small
// helper that forms a signed difference as sign and magnitude.
// ----------------------------------------------------------------------------
package spcm_pkg;

    // Field widths of the request and result items.
    localparam int POINT_X_W  = 10;
    localparam int POINT_Y_W  = 9;
    localparam int CURSOR_W   = 11;

    // Camera and display geometry.
    localparam int WINDOW_DEFAULT = 5;
    localparam logic [POINT_X_W-1:0] CAMERA_WIDTH   = 10'd640;
    localparam logic [CURSOR_W-1:0]  DISPLAY_WIDTH  = 11'd1920;
    localparam logic [CURSOR_W-1:0]  DISPLAY_HEIGHT = 11'd1080;

    // Mapping arithmetic: a difference magnitude times a display size.
    localparam int MAG_W = POINT_X_W;
    localparam int NUM_W = MAG_W + CURSOR_W;

    // Register interface.
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam logic [1:0] REG_LEFT_X   = 2'd0;
    localparam logic [1:0] REG_RIGHT_X  = 2'd1;
    localparam logic [1:0] REG_TOP_Y    = 2'd2;
    localparam logic [1:0] REG_BOTTOM_Y = 2'd3;

    // A difference split into its sign and its magnitude.
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } sdiff_t;

    // Returns a - b as sign and magnitude; both operands are unsigned.
    function automatic sdiff_t sub_mag(input logic [MAG_W-1:0] a,
                                       input logic [MAG_W-1:0] b);
        logic [MAG_W:0] d;
        logic [MAG_W:0] n;
        sdiff_t         r;
        d = {1'b0, a} - {1'b0, b};
        n = -d;
        r.neg = d[MAG_W];
        r.mag = d[MAG_W] ? n[MAG_W-1:0] : d[MAG_W-1:0];
        return r;
    endfunction

endpackage

@@ rtl/spcm_serial_div.sv @@
// ----------------------------------------------------------------------------
// Bit-serial restoring divider
// Unsigned division producing one quotient bit per cycle. A start loads the
// operands; done pulses for one cycle when the quotient is complete, and the
// quotient then holds until the next start.
// ----------------------------------------------------------------------------
module spcm_serial_div #(
    parameter int NUM_W = 13,
    parameter int DEN_W = 3
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [NUM_W-1:0] quo_next;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   rem_shift;
    logic [DEN_W:0]   trial;
    logic             fits;

    // One restoring step: bring down the next dividend bit and try a subtract.
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[NUM_W-1]};
        trial     = rem_shift - {1'b0, den_reg};
        fits      = ~trial[DEN_W];
        rem_next  = fits ? trial[DEN_W-1:0] : rem_shift[DEN_W-1:0];
        quo_next  = {quo_reg[NUM_W-2:0], fits};
    end

    // Step counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand and partial result shift registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/smoothed_point_to_cursor_map_core.sv @@
// ----------------------------------------------------------------------------
// Smoothed point to cursor map
// Mirrors the x of each camera point, averages the last WINDOW points and maps the
// averages linearly between calibration bounds to clamped display coordinates.
// ----------------------------------------------------------------------------
// Each request passes from acceptance to the result register through two
// bit-serial divisions in turn, one for the window averages and one for the
// calibration map, each producing a single quotient bit per cycle. One
// request is worked on at a time; the next may be accepted while the
// previous result still waits in the output register. Bounds are to be
// written over the APB port only while the block is idle; the block itself
// does not enforce this. A zero span forces the cursor coordinate to zero
// and raises the matching span flag.
// ----------------------------------------------------------------------------
module smoothed_point_to_cursor_map_core #(
    parameter int WINDOW = spcm_pkg::WINDOW_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Point requests
    input  logic                              point_valid,
    output logic                              point_stall,
    input  logic [spcm_pkg::POINT_X_W-1:0]    point_x,
    input  logic [spcm_pkg::POINT_Y_W-1:0]    point_y,
    // Results
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [spcm_pkg::POINT_X_W-1:0]    smooth_x,
    output logic [spcm_pkg::POINT_Y_W-1:0]    smooth_y,
    output logic [spcm_pkg::CURSOR_W-1:0]     cursor_x,
    output logic [spcm_pkg::CURSOR_W-1:0]     cursor_y,
    output logic                              x_span_zero,
    output logic                              y_span_zero,
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [spcm_pkg::ADDR_W-1:0]       paddr,
    input  logic [spcm_pkg::DATA_W-1:0]       pwdata,
    output logic [spcm_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);

    localparam int XW     = spcm_pkg::POINT_X_W;
    localparam int YW     = spcm_pkg::POINT_Y_W;
    localparam int MW     = spcm_pkg::MAG_W;
    localparam int CW     = spcm_pkg::CURSOR_W;
    localparam int NW     = spcm_pkg::NUM_W;
    localparam int DW     = spcm_pkg::DATA_W;
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SUM_W  = XW + FILL_W;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_AVG  = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_MAP  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [XW-1:0] left_x_reg;
    logic [XW-1:0] right_x_reg;
    logic [YW-1:0] top_y_reg;
    logic [YW-1:0] lower_y_reg;

    logic [XW-1:0]     win_x_reg [WINDOW];
    logic [YW-1:0]     win_y_reg [WINDOW];
    logic [SUM_W-1:0]  sum_x_reg;
    logic [SUM_W-1:0]  sum_x_next;
    logic [SUM_W-1:0]  sum_y_reg;
    logic [SUM_W-1:0]  sum_y_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              full;

    logic          accept;
    logic          cfg_write;
    logic [XW-1:0] px_sat;
    logic [XW-1:0] mirror_x;

    logic             avg_x_done;
    logic             avg_y_done;
    logic [SUM_W-1:0] avg_x_q;
    logic [SUM_W-1:0] avg_y_q;
    logic [XW-1:0]    avg_x;
    logic [YW-1:0]    avg_y;

    spcm_pkg::sdiff_t span_x;
    spcm_pkg::sdiff_t span_y;
    spcm_pkg::sdiff_t diff_x;
    spcm_pkg::sdiff_t diff_y;
    logic             span_x_zero;
    logic             span_y_zero;

    logic [NW-1:0] num_x_reg;
    logic [NW-1:0] num_y_reg;
    logic          flip_x_reg;
    logic          flip_y_reg;
    logic          map_start;
    logic          map_x_done;
    logic          map_y_done;
    logic [NW-1:0] map_x_q;
    logic [NW-1:0] map_y_q;
    logic [CW-1:0] cur_x;
    logic [CW-1:0] cur_y;
    logic          out_free;

    logic          result_valid_reg;
    logic [XW-1:0] smooth_x_reg;
    logic [YW-1:0] smooth_y_reg;
    logic [CW-1:0] cursor_x_reg;
    logic [CW-1:0] cursor_y_reg;
    logic          x_zero_reg;
    logic          y_zero_reg;

    // Handshakes.
    assign point_stall = (state_reg != ST_IDLE);
    assign accept      = point_valid && (state_reg == ST_IDLE);
    assign out_free    = !result_valid_reg || !result_stall;
    assign pready      = 1'b1;
    assign cfg_write   = psel && penable && pwrite;

    // Calibration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_x_reg  <= '0;
            right_x_reg <= '0;
            top_y_reg   <= '0;
            lower_y_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                spcm_pkg::REG_LEFT_X:   left_x_reg  <= pwdata[XW-1:0];
                spcm_pkg::REG_RIGHT_X:  right_x_reg <= pwdata[XW-1:0];
                spcm_pkg::REG_TOP_Y:    top_y_reg   <= pwdata[YW-1:0];
                spcm_pkg::REG_BOTTOM_Y: lower_y_reg <= pwdata[YW-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (paddr[3:2])
            spcm_pkg::REG_LEFT_X:   prdata = DW'(left_x_reg);
            spcm_pkg::REG_RIGHT_X:  prdata = DW'(right_x_reg);
            spcm_pkg::REG_TOP_Y:    prdata = DW'(top_y_reg);
            spcm_pkg::REG_BOTTOM_Y: prdata = DW'(lower_y_reg);
            default:                prdata = '0;
        endcase
    end

    // Mirror x, saturating points beyond the camera width.
    assign px_sat   = (point_x > spcm_pkg::CAMERA_WIDTH) ? spcm_pkg::CAMERA_WIDTH : point_x;
    assign mirror_x = spcm_pkg::CAMERA_WIDTH - px_sat;

    // Running sums: drop the oldest point once the window is full.
    assign full = (fill_reg == FILL_W'(WINDOW));

    always_comb
    begin
        sum_x_next = sum_x_reg + SUM_W'(mirror_x);
        sum_y_next = sum_y_reg + SUM_W'(point_y);
        fill_next  = fill_reg + 1'b1;
        if (full)
        begin
            sum_x_next = sum_x_reg + SUM_W'(mirror_x) - SUM_W'(win_x_reg[WINDOW-1]);
            sum_y_next = sum_y_reg + SUM_W'(point_y) - SUM_W'(win_y_reg[WINDOW-1]);
            fill_next  = fill_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            fill_reg  <= '0;
        end
        else if (accept)
        begin
            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;
            fill_reg  <= fill_next;
        end
    end

    // Window shift line, newest point at the head and oldest at the tail.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            win_x_reg[0] <= mirror_x;
            win_y_reg[0] <= point_y;
            for (int i = 1; i < WINDOW; i++)
            begin
                win_x_reg[i] <= win_x_reg[i-1];
                win_y_reg[i] <= win_y_reg[i-1];
            end
        end
    end

    // Window averages, divided by the number of points held.
    spcm_serial_div #(.NUM_W(SUM_W), .DEN_W(FILL_W)) u_avg_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .dividend (sum_x_next),
        .divisor  (fill_next),
        .done     (avg_x_done),
        .quotient (avg_x_q)
    );

    spcm_serial_div #(.NUM_W(SUM_W), .DEN_W(FILL_W)) u_avg_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .dividend (sum_y_next),
        .divisor  (fill_next),
        .done     (avg_y_done),
        .quotient (avg_y_q)
    );

    // An average never exceeds its largest point, so it fits the field.
    assign avg_x = avg_x_q[XW-1:0];
    assign avg_y = avg_y_q[YW-1:0];

    // Calibration spans and offsets as sign and magnitude.
    assign span_x      = spcm_pkg::sub_mag(left_x_reg, right_x_reg);
    assign span_y      = spcm_pkg::sub_mag(MW'(lower_y_reg), MW'(top_y_reg));
    assign diff_x      = spcm_pkg::sub_mag(avg_x, right_x_reg);
    assign diff_y      = spcm_pkg::sub_mag(MW'(avg_y), MW'(top_y_reg));
    assign span_x_zero = (left_x_reg == right_x_reg);
    assign span_y_zero = (lower_y_reg == top_y_reg);

    // Scale the offset magnitudes by the display size.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_AVG && avg_x_done && avg_y_done)
        begin
            num_x_reg  <= NW'(diff_x.mag) * NW'(spcm_pkg::DISPLAY_WIDTH);
            num_y_reg  <= NW'(diff_y.mag) * NW'(spcm_pkg::DISPLAY_HEIGHT);
            flip_x_reg <= diff_x.neg ^ span_x.neg;
            flip_y_reg <= diff_y.neg ^ span_y.neg;
        end
    end

    assign map_start = (state_reg == ST_MUL);

    // Divide the scaled offsets by the span magnitudes.
    spcm_serial_div #(.NUM_W(NW), .DEN_W(MW)) u_map_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (map_start),
        .dividend (num_x_reg),
        .divisor  (span_x.mag),
        .done     (map_x_done),
        .quotient (map_x_q)
    );

    spcm_serial_div #(.NUM_W(NW), .DEN_W(MW)) u_map_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (map_start),
        .dividend (num_y_reg),
        .divisor  (span_y.mag),
        .done     (map_y_done),
        .quotient (map_y_q)
    );

    // A negative quotient or a zero span clamps to zero, a large quotient to the display size.
    always_comb
    begin
        cur_x = CW'(map_x_q);
        cur_y = CW'(map_y_q);
        if (map_x_q > NW'(spcm_pkg::DISPLAY_WIDTH))
        begin
            cur_x = spcm_pkg::DISPLAY_WIDTH;
        end
        if (map_y_q > NW'(spcm_pkg::DISPLAY_HEIGHT))
        begin
            cur_y = spcm_pkg::DISPLAY_HEIGHT;
        end
        if (flip_x_reg || span_x_zero)
        begin
            cur_x = '0;
        end
        if (flip_y_reg || span_y_zero)
        begin
            cur_y = '0;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_AVG;
                end
            end
            ST_AVG:
            begin
                if (avg_x_done && avg_y_done)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_MAP;
            end
            ST_MAP:
            begin
                if (map_x_done && map_y_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Output register, loaded once the previous result has been taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_DONE && out_free)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && out_free)
        begin
            smooth_x_reg <= avg_x;
            smooth_y_reg <= avg_y;
            cursor_x_reg <= cur_x;
            cursor_y_reg <= cur_y;
            x_zero_reg   <= span_x_zero;
            y_zero_reg   <= span_y_zero;
        end
    end

    assign result_valid = result_valid_reg;
    assign smooth_x     = smooth_x_reg;
    assign smooth_y     = smooth_y_reg;
    assign cursor_x     = cursor_x_reg;
    assign cursor_y     = cursor_y_reg;
    assign x_span_zero  = x_zero_reg;
    assign y_span_zero  = y_zero_reg;

    // A new result only appears when the sequencer hands one over.
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result appeared without a finished request");

    // The average dividers finish only while the sequencer waits for them.
    a_avg_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        avg_x_done |-> state_reg == ST_AVG)
        else $error("average division finished outside its phase");

    // The map dividers finish only while the sequencer waits for them.
    a_map_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        map_x_done |-> state_reg == ST_MAP)
        else $error("map division finished outside its phase");

    // A request in flight always has at least one point in the window.
    a_fill_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> fill_reg != '0 && fill_reg <= FILL_W'(WINDOW))
        else $error("window fill count out of range");

    // Held cursor values stay inside the display and honour the span flags.
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> cursor_x_reg <= spcm_pkg::DISPLAY_WIDTH
            && cursor_y_reg <= spcm_pkg::DISPLAY_HEIGHT
            && (!x_zero_reg || cursor_x_reg == '0)
            && (!y_zero_reg || cursor_y_reg == '0))
        else $error("cursor result out of range");

endmodule

@@ test/cursor_map_checker.sv @@
// ----------------------------------------------------------------------------
// Smoothed point to cursor map: result checker
// Watches the point, result and configuration channels, keeps its own copy of
// the averaging window and the calibration bounds, works out the expected
// result of every accepted request and compares each delivered result with it.
// ----------------------------------------------------------------------------
module cursor_map_checker
    import spcm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 point_valid,
    input  logic                 point_stall,
    input  logic [POINT_X_W-1:0] point_x,
    input  logic [POINT_Y_W-1:0] point_y,
    input  logic                 result_valid,
    input  logic                 result_stall,
    input  logic [POINT_X_W-1:0] smooth_x,
    input  logic [POINT_Y_W-1:0] smooth_y,
    input  logic [CURSOR_W-1:0]  cursor_x,
    input  logic [CURSOR_W-1:0]  cursor_y,
    input  logic                 x_span_zero,
    input  logic                 y_span_zero,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic                 pready,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output int                   mismatch_count,
    output int                   pending_count
);

    localparam int AVG_DEPTH    = WINDOW_DEFAULT;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [POINT_X_W-1:0] smooth_x;
        logic [POINT_Y_W-1:0] smooth_y;
        logic [CURSOR_W-1:0]  cursor_x;
        logic [CURSOR_W-1:0]  cursor_y;
        logic                 x_span_zero;
        logic                 y_span_zero;
    } cursor_result_t;

    // Averaging window and calibration bounds as the block should hold them.
    logic [POINT_X_W-1:0] hist_x [AVG_DEPTH];
    logic [POINT_Y_W-1:0] hist_y [AVG_DEPTH];
    int unsigned          total_x;
    int unsigned          total_y;
    int unsigned          fill;
    int unsigned          next_slot;
    int unsigned          left_x;
    int unsigned          right_x;
    int unsigned          top_y;
    int unsigned          lower_y;

    cursor_result_t       expected_q [$];
    int                   errors;

    // Linear map so that lo lands on zero and hi on size, truncated toward
    // zero and clamped to the display range. A zero span yields zero.
    function automatic logic [CURSOR_W-1:0] map_to_display(input int unsigned v,
                                                           input int unsigned lo,
                                                           input int unsigned hi,
                                                           input int unsigned size);
        longint span;
        longint q;
        span = longint'(hi) - longint'(lo);
        if (span == 0)
            return '0;
        q = ((longint'(v) - longint'(lo)) * longint'(size)) / span;
        if (q < 0)
            q = 0;
        if (q > longint'(size))
            q = size;
        return q[CURSOR_W-1:0];
    endfunction

    // Slides one point into the window and queues the result it should cause.
    task automatic advance_window(input logic [POINT_X_W-1:0] px,
                                  input logic [POINT_Y_W-1:0] py);
        cursor_result_t r;
        int unsigned    mx;
        int unsigned    avg_x;
        int unsigned    avg_y;
        mx = (px > CAMERA_WIDTH) ? 0 : CAMERA_WIDTH - px;
        if (fill >= AVG_DEPTH)
        begin
            total_x -= hist_x[next_slot];
            total_y -= hist_y[next_slot];
        end
        else
        begin
            fill++;
        end
        hist_x[next_slot] = mx[POINT_X_W-1:0];
        hist_y[next_slot] = py;
        total_x += mx;
        total_y += py;
        next_slot = (next_slot + 1 >= AVG_DEPTH) ? 0 : next_slot + 1;
        avg_x = total_x / fill;
        avg_y = total_y / fill;
        r.smooth_x    = avg_x[POINT_X_W-1:0];
        r.smooth_y    = avg_y[POINT_Y_W-1:0];
        r.cursor_x    = map_to_display(avg_x, right_x, left_x, DISPLAY_WIDTH);
        r.cursor_y    = map_to_display(avg_y, top_y, lower_y, DISPLAY_HEIGHT);
        r.x_span_zero = (left_x == right_x);
        r.y_span_zero = (top_y == lower_y);
        expected_q.insert(expected_q.size(), r);
    endtask

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("mismatch on %s: expected %0d, got %0d", field, want, got);
        end
    endtask

    // Everything is sampled at the rising edge, before the edge's own updates.
    always @(posedge clk or negedge rst_n)
    begin : track
        cursor_result_t want;
        if (!rst_n)
        begin
            total_x   = 0;
            total_y   = 0;
            fill      = 0;
            next_slot = 0;
            left_x    = 0;
            right_x   = 0;
            top_y     = 0;
            lower_y   = 0;
            errors    = 0;
            expected_q.delete();
            mismatch_count <= 0;
            pending_count  <= 0;
        end
        else
        begin
            // Calibration writes land at the access edge.
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_LEFT_X:   left_x  = pwdata[POINT_X_W-1:0];
                    REG_RIGHT_X:  right_x = pwdata[POINT_X_W-1:0];
                    REG_TOP_Y:    top_y   = pwdata[POINT_Y_W-1:0];
                    REG_BOTTOM_Y: lower_y = pwdata[POINT_Y_W-1:0];
                    default: ;
                endcase
            end

            if (point_valid && !point_stall)
                advance_window(point_x, point_y);

            // Each delivered result is held against the oldest expectation.
            if (result_valid && !result_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("unexpected result: smooth %0d,%0d cursor %0d,%0d",
                                 smooth_x, smooth_y, cursor_x, cursor_y);
                end
                else
                begin
                    want = expected_q.pop_front();
                    compare_field("smooth_x", want.smooth_x, smooth_x);
                    compare_field("smooth_y", want.smooth_y, smooth_y);
                    compare_field("cursor_x", want.cursor_x, cursor_x);
                    compare_field("cursor_y", want.cursor_y, cursor_y);
                    compare_field("x_span_zero", want.x_span_zero, x_span_zero);
                    compare_field("y_span_zero", want.y_span_zero, y_span_zero);
                end
            end

            mismatch_count <= errors;
            pending_count  <= expected_q.size();
        end
    end

endmodule

@@ test/smoothed_point_to_cursor_map_core_test.sv @@
// ----------------------------------------------------------------------------
// Smoothed point to cursor map: testbench top
// Drives camera points and calibration writes into the block under a range of
// idling and stall patterns, including a long output hold-off, while a
// separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module smoothed_point_to_cursor_map_core_test;
    import spcm_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 80;
    localparam int PHASE_ITEMS   = 85;
    localparam int PHASE_COUNT   = 8;
    localparam int BURST_ITEMS   = 24;

    logic                 clk;
    logic                 rst_n          = 1'b0;
    logic                 point_valid    = 1'b0;
    logic                 point_stall;
    logic [POINT_X_W-1:0] point_x        = '0;
    logic [POINT_Y_W-1:0] point_y        = '0;
    logic                 result_valid;
    logic                 result_stall   = 1'b0;
    logic [POINT_X_W-1:0] smooth_x;
    logic [POINT_Y_W-1:0] smooth_y;
    logic [CURSOR_W-1:0]  cursor_x;
    logic [CURSOR_W-1:0]  cursor_y;
    logic                 x_span_zero;
    logic                 y_span_zero;
    logic                 psel           = 1'b0;
    logic                 penable        = 1'b0;
    logic                 pwrite         = 1'b0;
    logic [ADDR_W-1:0]    paddr          = '0;
    logic [DATA_W-1:0]    pwdata         = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    int                   mismatch_count;
    int                   pending_count;
    int unsigned          send_idle_pct  = 0;
    int unsigned          recv_stall_pct = 0;
    logic                 hold_req       = 1'b0;
    int unsigned          hold_count     = 0;
    int unsigned          cycle_count    = 0;
    int                   aim_x          = 320;
    int                   aim_y          = 240;

    smoothed_point_to_cursor_map_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_valid),
        .point_stall  (point_stall),
        .point_x      (point_x),
        .point_y      (point_y),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .smooth_x     (smooth_x),
        .smooth_y     (smooth_y),
        .cursor_x     (cursor_x),
        .cursor_y     (cursor_y),
        .x_span_zero  (x_span_zero),
        .y_span_zero  (y_span_zero),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    cursor_map_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .point_valid    (point_valid),
        .point_stall    (point_stall),
        .point_x        (point_x),
        .point_y        (point_y),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .smooth_x       (smooth_x),
        .smooth_y       (smooth_y),
        .cursor_x       (cursor_x),
        .cursor_y       (cursor_y),
        .x_span_zero    (x_span_zero),
        .y_span_zero    (y_span_zero),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side: random stalls, or a long hold-off while one is requested.
    always @(posedge clk)
    begin
        if (hold_req && hold_count < HOLD_CYCLES)
        begin
            result_stall <= 1'b1;
            hold_count   <= hold_count + 1;
        end
        else
        begin
            if (!hold_req)
                hold_count <= 0;
            result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // One APB write: setup phase, access phase, then an idle phase.
    task automatic apb_write(input logic [1:0] index, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_bounds(input int unsigned left, input int unsigned right,
                                input int unsigned top, input int unsigned bottom);
        apb_write(REG_LEFT_X, left);
        apb_write(REG_RIGHT_X, right);
        apb_write(REG_TOP_Y, top);
        apb_write(REG_BOTTOM_Y, bottom);
    endtask

    // Offers one point request, after a random gap, and waits for acceptance.
    task automatic send_point(input logic [POINT_X_W-1:0] x,
                              input logic [POINT_Y_W-1:0] y);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            point_valid <= 1'b0;
            @(posedge clk);
        end
        point_valid <= 1'b1;
        point_x     <= x;
        point_y     <= y;
        do
            @(posedge clk);
        while (point_stall);
    endtask

    // Mostly a wandering point with jitter, as a tracked face would give,
    // with some uniform points and some beyond the camera frame.
    task automatic send_random_point();
        int unsigned pick;
        int          x;
        int          y;
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            x = $urandom_range(0, 1023);
            y = $urandom_range(0, 511);
        end
        else if (pick < 30)
        begin
            x = $urandom_range(0, 640);
            y = $urandom_range(0, 480);
        end
        else
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                aim_x = $urandom_range(0, 640);
                aim_y = $urandom_range(0, 480);
            end
            x = aim_x + int'($urandom_range(0, 24)) - 12;
            y = aim_y + int'($urandom_range(0, 24)) - 12;
            x = (x < 0) ? 0 : (x > 640) ? 640 : x;
            y = (y < 0) ? 0 : (y > 480) ? 480 : y;
        end
        send_point(x[POINT_X_W-1:0], y[POINT_Y_W-1:0]);
    endtask

    // Stops offering requests and waits until every result has come back.
    task automatic drain();
        point_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    task automatic set_idling(input int unsigned mode);
        case (mode)
            0:
            begin
                send_idle_pct   = 0;
                recv_stall_pct <= 0;
            end
            1:
            begin
                send_idle_pct   = 53;
                recv_stall_pct <= 0;
            end
            2:
            begin
                send_idle_pct   = 0;
                recv_stall_pct <= 53;
            end
            default:
            begin
                send_idle_pct   = 20;
                recv_stall_pct <= 20;
            end
        endcase
    endtask

    initial
    begin : stimulus
        int unsigned ph;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Bounds still at reset: both spans are zero.
        send_point(10'd0, 9'd0);
        send_point(10'd1023, 9'd511);
        drain();

        // Field extremes, saturation beyond the camera width, y beyond the
        // camera height, a steady window, and averages beyond both bounds.
        write_bounds(600, 40, 40, 440);
        send_point(10'd640, 9'd480);
        send_point(10'd0, 9'd0);
        send_point(10'd641, 9'd0);
        send_point(10'd1023, 9'd511);
        repeat (5) send_point(10'd320, 9'd240);
        repeat (5) send_point(10'd0, 9'd0);
        repeat (5) send_point(10'd640, 9'd480);
        drain();

        // Reversed bounds use the negated span.
        write_bounds(0, 640, 480, 0);
        send_point(10'd100, 9'd100);
        send_point(10'd500, 9'd400);
        drain();

        // Random phases, each under its own calibration and idling pattern.
        for (ph = 0; ph < PHASE_COUNT; ph++)
        begin
            case (ph)
                0: write_bounds(600, 40, 40, 440);
                1: write_bounds(640, 0, 0, 480);
                2: write_bounds(0, 640, 480, 0);
                3: write_bounds(1023, 1023, 511, 0);
                4: write_bounds(321, 320, 240, 241);
                5: write_bounds($urandom_range(0, 1023), $urandom_range(0, 1023),
                                $urandom_range(0, 511), $urandom_range(0, 511));
                6: write_bounds($urandom_range(0, 640), $urandom_range(0, 640),
                                $urandom_range(0, 480), $urandom_range(0, 480));
                default: write_bounds(500, 100, 400, 60);
            endcase
            set_idling(ph % 4);
            repeat (PHASE_ITEMS) send_random_point();
            drain();
        end

        // Long output hold-off while requests keep coming, so the block backs up.
        set_idling(0);
        hold_req <= 1'b1;
        repeat (BURST_ITEMS) send_random_point();
        hold_req <= 1'b0;
        drain();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ files.f @@
rtl/spcm_pkg.sv
rtl/spcm_serial_div.sv
rtl/smoothed_point_to_cursor_map_core.sv
test/cursor_map_checker.sv
test/smoothed_point_to_cursor_map_core_test.sv
